>>> sv/ssl_pkg.sv
// Shared types, codes and helpers for the substitution score lookup unit.
// Used by the top level; no dependencies.
package ssl_pkg;

  // Default parameter values
  localparam int unsigned WildcardSlotsDef = 16;
  localparam int unsigned CharBitsDef      = 8;
  localparam int unsigned ScoreBitsDef     = 16;

  // Fixed field widths
  localparam int unsigned KindW     = 2;
  localparam int unsigned FieldChW  = 8;
  localparam int unsigned ScoreW    = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // ASCII upper-case range and the offset to lower case
  localparam logic [FieldChW-1:0] CharUpperA = 8'h41;
  localparam logic [FieldChW-1:0] CharUpperZ = 8'h5A;
  localparam logic [FieldChW-1:0] CaseOffset = 8'h20;

  // Reset values of the configuration registers
  localparam logic [ScoreW-1:0] MatchScoreRst    = 16'h0001;
  localparam logic [ScoreW-1:0] MismatchScoreRst = 16'hFFFE;

  typedef enum logic [KindW-1:0] {
    KIND_LOOKUP   = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_WILDCARD = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH    = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_USE_MM   = 2'd2,
    CFG_CASE     = 2'd3
  } cfg_reg_e;

  // Fold A-Z to a-z unless case sensitive
  function automatic logic [FieldChW-1:0] fold_char(logic [FieldChW-1:0] c, logic case_sens);
    logic [FieldChW-1:0] r;
    r = c;
    if (!case_sens && c >= CharUpperA && c <= CharUpperZ) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

>>> sv/ssl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ssl_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/substitution_score_lookup_unit.sv
// Substitution score lookup unit: pair table, wildcard bank and fallback scoring.
// Depends on ssl_pkg and ssl_ram.
//
// Usage:
//   Items enter on start/kind_i/char_a_i/char_b_i/score_in_i and are taken at a
//   rising edge with start high and busy low. Every item gives one result beat
//   on score_out_o/status_o, marked by done_o for one cycle, after the item has
//   passed the stage 1 registers and the result registers. The receiver cannot hold results off.
//   Throughput is one item per cycle while busy is low: the pair table is one RAM
//   with a write port and a registered read port; a table write lands at the edge
//   that takes it, so a lookup taken at any later edge already reads the new entry.
//   Wildcards sit in a small register bank searched in parallel in stage 1,
//   first slot wins.
//   After reset the pair table is swept clear, one entry a cycle, through all
//   2^(2*CHAR_BITS) entries (65536 at the defaults); busy stays high meanwhile.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   edge they are presented, and may be made at any time the unit is idle,
//   including during the sweep.
module substitution_score_lookup_unit #(
  parameter int unsigned WILDCARD_SLOTS = ssl_pkg::WildcardSlotsDef,
  parameter int unsigned CHAR_BITS      = ssl_pkg::CharBitsDef,
  parameter int unsigned SCORE_BITS     = ssl_pkg::ScoreBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [ssl_pkg::KindW-1:0]          kind_i,
  input  logic [ssl_pkg::FieldChW-1:0]       char_a_i,
  input  logic [ssl_pkg::FieldChW-1:0]       char_b_i,
  input  logic signed [ssl_pkg::ScoreW-1:0]  score_in_i,
  // Result channel
  output logic                               done_o,
  output logic signed [ssl_pkg::ScoreW-1:0]  score_out_o,
  output logic [ssl_pkg::StatusW-1:0]        status_o,
  // Configuration port
  input  logic                               cfg_we_i,
  input  logic [ssl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ssl_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned AddrW  = 2 * CHAR_BITS;
  localparam int unsigned Depth  = 1 << AddrW;
  localparam int unsigned StoreW = (SCORE_BITS < ssl_pkg::ScoreW) ? SCORE_BITS : ssl_pkg::ScoreW;
  localparam int unsigned RamW   = StoreW + 1;
  localparam int unsigned CntW   = $clog2(WILDCARD_SLOTS + 1);

  // Configuration registers
  logic signed [ssl_pkg::ScoreW-1:0] match_q, mismatch_q;
  logic                              use_mm_q, case_sens_q;

  // Clearing sweep
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;

  // Stage 0 signals
  logic                  accept;
  ssl_pkg::kind_e        kind;
  logic [ssl_pkg::FieldChW-1:0] a_raw, b_raw, a_fold, b_fold;
  logic [CHAR_BITS-1:0]  a_key, b_key;
  logic                  wc_full, wc_add;

  // Pair table RAM
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RamW-1:0]  ram_wdata;
  logic [RamW-1:0]  ram_rdata;

  // Wildcard bank
  logic [CHAR_BITS-1:0] wc_char_q  [WILDCARD_SLOTS];
  logic [StoreW-1:0]    wc_score_q [WILDCARD_SLOTS];
  logic [CntW-1:0]      wc_count_q;

  // Stage 1 registers
  logic                 s1_valid_q;
  ssl_pkg::kind_e       s1_kind_q;
  logic [CHAR_BITS-1:0] s1_a_q, s1_b_q;
  logic                 s1_full_q;

  // Stage 1 signals
  logic                            wc_hit;
  logic signed [StoreW-1:0]        wc_sel, tab_score;
  logic signed [ssl_pkg::ScoreW-1:0] score_d;
  ssl_pkg::status_e                status_d;

  // Result registers
  logic                              done_q;
  logic signed [ssl_pkg::ScoreW-1:0] score_q;
  ssl_pkg::status_e                  status_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= ssl_pkg::MatchScoreRst;
      mismatch_q  <= ssl_pkg::MismatchScoreRst;
      use_mm_q    <= 1'b1;
      case_sens_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ssl_pkg::cfg_reg_e'(cfg_idx_i))
        ssl_pkg::CFG_MATCH:    match_q     <= cfg_data_i;
        ssl_pkg::CFG_MISMATCH: mismatch_q  <= cfg_data_i;
        ssl_pkg::CFG_USE_MM:   use_mm_q    <= cfg_data_i[0];
        ssl_pkg::CFG_CASE:     case_sens_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sweep the pair table clear after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {AddrW{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign busy = clr_q;

  // Stage 0: take the item, fold the characters, address the table
  assign accept = start && !clr_q;
  assign kind   = ssl_pkg::kind_e'(kind_i);
  assign a_raw  = ssl_pkg::FieldChW'(char_a_i[CHAR_BITS-1:0]);
  assign b_raw  = ssl_pkg::FieldChW'(char_b_i[CHAR_BITS-1:0]);
  assign a_fold = ssl_pkg::fold_char(a_raw, case_sens_q);
  assign b_fold = ssl_pkg::fold_char(b_raw, case_sens_q);
  assign a_key  = a_fold[CHAR_BITS-1:0];
  assign b_key  = b_fold[CHAR_BITS-1:0];

  assign wc_full = (wc_count_q == CntW'(WILDCARD_SLOTS));
  assign wc_add  = accept && (kind == ssl_pkg::KIND_WILDCARD) && !wc_full;

  // Steer the table write port between the sweep and table write beats
  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && (kind == ssl_pkg::KIND_WRITE);
      ram_waddr = {char_a_i[CHAR_BITS-1:0], char_b_i[CHAR_BITS-1:0]};
      ram_wdata = {1'b1, score_in_i[StoreW-1:0]};
    end
  end

  ssl_ram #(
    .WIDTH (RamW),
    .DEPTH (Depth)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({a_key, b_key}),
    .rdata_o (ram_rdata)
  );

  // Append a wildcard to the next free slot
  for (genvar i = 0; i < WILDCARD_SLOTS; i++) begin : g_wc_slot
    always_ff @(posedge clk_i) begin
      if (wc_add && wc_count_q == CntW'(i)) begin
        wc_char_q[i]  <= a_key;
        wc_score_q[i] <= score_in_i[StoreW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_count_q <= '0;
    end else if (wc_add) begin
      wc_count_q <= wc_count_q + 1'b1;
    end
  end

  // Advance the item into stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind;
      s1_a_q    <= a_key;
      s1_b_q    <= b_key;
      s1_full_q <= wc_full;
    end
  end

  // Stage 1: find the first live wildcard matching either character
  always_comb begin
    wc_hit = 1'b0;
    wc_sel = '0;
    for (int i = WILDCARD_SLOTS - 1; i >= 0; i--) begin
      if (CntW'(i) < wc_count_q && (wc_char_q[i] == s1_a_q || wc_char_q[i] == s1_b_q)) begin
        wc_hit = 1'b1;
        wc_sel = wc_score_q[i];
      end
    end
  end

  assign tab_score = ram_rdata[StoreW-1:0];

  // Lookup by priority: table, wildcard, match/mismatch, else UNKNOWN; wildcard add: FULL/OK
  always_comb begin
    score_d  = '0;
    status_d = ssl_pkg::ST_OK;
    case (s1_kind_q)
      ssl_pkg::KIND_LOOKUP: begin
        if (ram_rdata[StoreW]) begin
          score_d = ssl_pkg::ScoreW'(tab_score);
        end else if (wc_hit) begin
          score_d = ssl_pkg::ScoreW'(wc_sel);
        end else if (use_mm_q) begin
          score_d = (s1_a_q == s1_b_q) ? match_q : mismatch_q;
        end else begin
          status_d = ssl_pkg::ST_UNKNOWN;
        end
      end
      ssl_pkg::KIND_WILDCARD: begin
        status_d = s1_full_q ? ssl_pkg::ST_FULL : ssl_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      score_q  <= score_d;
      status_q <= status_d;
    end
  end

  assign done_o      = done_q;
  assign score_out_o = score_q;
  assign status_o    = status_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for substitution_score_lookup_unit: directed and random items,
// predicted per beat by a scoreboard class and compared field by field.
// Depends on ssl_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import ssl_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PairDepth = 1 << (2 * FieldChW);
  localparam int unsigned RecentDepth = 8;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    status_e           status;
  } score_beat_t;

  // Scoreboard: own copy of tables, wildcards and registers; queue of expected beats
  class score_tracker;
    logic [ScoreW-1:0]   match_val;
    logic [ScoreW-1:0]   mismatch_val;
    bit                  fallback_on;
    bit                  case_sens;
    logic [ScoreW-1:0]   pair_score [PairDepth];
    bit                  pair_written [PairDepth];
    logic [FieldChW-1:0] wild_char [WildcardSlotsDef];
    logic [ScoreW-1:0]   wild_score [WildcardSlotsDef];
    int                  wild_count;
    score_beat_t         expected_scores [$];
    int                  errors;

    function new();
      match_val    = MatchScoreRst;
      mismatch_val = MismatchScoreRst;
      fallback_on  = 1'b1;
      case_sens    = 1'b0;
      wild_count   = 0;
      errors       = 0;
      foreach (pair_written[i]) pair_written[i] = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_MATCH:    match_val    = data[ScoreW-1:0];
        CFG_MISMATCH: mismatch_val = data[ScoreW-1:0];
        CFG_USE_MM:   fallback_on  = data[0];
        CFG_CASE:     case_sens    = data[0];
        default: ;
      endcase
    endfunction

    function logic [FieldChW-1:0] lower(logic [FieldChW-1:0] c);
      if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    // Work out the beat that one accepted item causes and update the state
    function void note_item(logic [KindW-1:0] kind, logic [FieldChW-1:0] ca,
                            logic [FieldChW-1:0] cb, logic [ScoreW-1:0] sc);
      score_beat_t         beat;
      logic [FieldChW-1:0] fa;
      logic [FieldChW-1:0] fb;
      bit                  hit;
      beat.score  = '0;
      beat.status = ST_OK;
      hit         = 1'b0;
      case (kind)
        KIND_LOOKUP: begin
          fa = lower(ca);
          fb = lower(cb);
          if (pair_written[{fa, fb}]) begin
            beat.score = pair_score[{fa, fb}];
            hit = 1'b1;
          end
          for (int i = 0; i < wild_count && !hit; i++) begin
            if (wild_char[i] == fa || wild_char[i] == fb) begin
              beat.score = wild_score[i];
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (fallback_on) beat.score = (fa == fb) ? match_val : mismatch_val;
            else beat.status = ST_UNKNOWN;
          end
        end
        KIND_WRITE: begin
          pair_score[{ca, cb}]   = sc;
          pair_written[{ca, cb}] = 1'b1;
        end
        KIND_WILDCARD: begin
          if (wild_count < WildcardSlotsDef) begin
            wild_char[wild_count]  = lower(ca);
            wild_score[wild_count] = sc;
            wild_count++;
          end else begin
            beat.status = ST_FULL;
          end
        end
        default: ;
      endcase
      expected_scores.push_back(beat);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one result beat with the oldest expectation
    task check_result(logic [ScoreW-1:0] got_score, logic [StatusW-1:0] got_status);
      score_beat_t exp_beat;
      if (expected_scores.size() == 0) begin
        report($sformatf("result beat with nothing expected: score %0d status %0d",
                         $signed(got_score), got_status));
      end else begin
        exp_beat = expected_scores.pop_front();
        if (got_score !== exp_beat.score) begin
          report($sformatf("score_out %0d, expected %0d", $signed(got_score),
                           $signed(exp_beat.score)));
        end
        if (got_status !== exp_beat.status) begin
          report($sformatf("status %0d, expected %0d", got_status, exp_beat.status));
        end
      end
    endtask

    function int outstanding();
      return expected_scores.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start;
  logic                       busy;
  logic [KindW-1:0]           kind_i;
  logic [FieldChW-1:0]        char_a_i;
  logic [FieldChW-1:0]        char_b_i;
  logic signed [ScoreW-1:0]   score_in_i;
  logic                       done_o;
  logic signed [ScoreW-1:0]   score_out_o;
  logic [StatusW-1:0]         status_o;
  logic                       cfg_we_i;
  logic [CfgIdxW-1:0]         cfg_idx_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  score_tracker        board;
  int unsigned         cycles = 0;
  logic [FieldChW-1:0] recent_a [RecentDepth];
  logic [FieldChW-1:0] recent_b [RecentDepth];
  int                  recent_fill = 0;

  substitution_score_lookup_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .char_a_i    (char_a_i),
    .char_b_i    (char_b_i),
    .score_in_i  (score_in_i),
    .done_o      (done_o),
    .score_out_o (score_out_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every result beat at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(score_out_o, status_o);
  end

  // Present one item and hold it until the unit takes it
  task automatic drive_item(logic [KindW-1:0] kind, logic [FieldChW-1:0] ca,
                            logic [FieldChW-1:0] cb, logic [ScoreW-1:0] sc);
    start      <= 1'b1;
    kind_i     <= kind;
    char_a_i   <= ca;
    char_b_i   <= cb;
    score_in_i <= sc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(kind, ca, cb, sc);
  endtask

  // Write all four registers, one per cycle, with the item side quiet
  task automatic write_regs(logic [ScoreW-1:0] m, logic [ScoreW-1:0] mm,
                            logic use_mm, logic cs);
    logic [CfgDataW-1:0] vals [4];
    vals[0] = m;
    vals[1] = mm;
    vals[2] = {{(CfgDataW-1){1'b0}}, use_mm};
    vals[3] = {{(CfgDataW-1){1'b0}}, cs};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      board.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FieldChW-1:0] pick_char();
    logic [FieldChW-1:0] c;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      // small alphabet so pairs and wildcards recur
      c = 8'h61 + 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) c = c - 8'h20;
    end else if (r <= 7) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 9))
        0: c = 8'h00;
        1: c = 8'hFF;
        2: c = 8'h40;
        3: c = 8'h41;
        4: c = 8'h5A;
        5: c = 8'h5B;
        6: c = 8'h60;
        7: c = 8'h61;
        8: c = 8'h7A;
        default: c = 8'h7B;
      endcase
    end
    return c;
  endfunction

  function automatic logic [FieldChW-1:0] flip_case(logic [FieldChW-1:0] c);
    if ($urandom_range(0, 1) == 1 &&
        ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly lookups, many aimed at pairs written lately; wildcards stay rare
  task automatic make_item(output logic [KindW-1:0] kind, output logic [FieldChW-1:0] ca,
                           output logic [FieldChW-1:0] cb, output logic [ScoreW-1:0] sc);
    int unsigned r;
    int unsigned slot;
    r  = $urandom_range(0, 99);
    ca = pick_char();
    cb = pick_char();
    sc = pick_score();
    if (r < 60) begin
      kind = KIND_LOOKUP;
      if (recent_fill > 0 && $urandom_range(0, 99) < 35) begin
        slot = $urandom_range(0, (recent_fill < RecentDepth ? recent_fill : RecentDepth) - 1);
        ca = flip_case(recent_a[slot]);
        cb = flip_case(recent_b[slot]);
      end
    end else if (r < 94) begin
      kind = KIND_WRITE;
      recent_a[recent_fill % RecentDepth] = ca;
      recent_b[recent_fill % RecentDepth] = cb;
      recent_fill++;
    end else if (r < 96) begin
      kind = KIND_WILDCARD;
    end else begin
      kind = KindUnused;
    end
  endtask

  // Random items in bursts with random gaps; ignored items do not count
  task automatic run_phase(int items);
    logic [KindW-1:0]    kind;
    logic [FieldChW-1:0] ca;
    logic [FieldChW-1:0] cb;
    logic [ScoreW-1:0]   sc;
    int                  done_items;
    int unsigned         burst;
    int unsigned         gap;
    done_items = 0;
    while (done_items < items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && done_items < items; k++) begin
        make_item(kind, ca, cb, sc);
        drive_item(kind, ca, cb, sc);
        if (kind != KindUnused) done_items++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    board      = new();
    start      <= 1'b0;
    kind_i     <= KIND_LOOKUP;
    char_a_i   <= '0;
    char_b_i   <= '0;
    score_in_i <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_MATCH;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset settings, back to back
    drive_item(KIND_LOOKUP,   "a",   "a",   16'h0000);  // equal pair
    drive_item(KIND_LOOKUP,   "a",   "b",   16'h7FFF);  // differing pair
    drive_item(KIND_LOOKUP,   "A",   "a",   16'h0000);  // equal once folded
    drive_item(KIND_LOOKUP,   8'h00, 8'hFF, 16'h8000);
    drive_item(KIND_WRITE,    "a",   "b",   16'h7FFF);
    drive_item(KIND_LOOKUP,   "A",   "B",   16'h0000);  // table hit after folding
    drive_item(KIND_WRITE,    "C",   "D",   16'h8000);  // stored unfolded
    drive_item(KIND_LOOKUP,   "C",   "D",   16'h0000);  // folds past the entry
    drive_item(KIND_WRITE,    8'hFF, 8'h00, 16'hFFFF);
    drive_item(KIND_LOOKUP,   8'hFF, 8'h00, 16'h0000);
    drive_item(KIND_WRITE,    "a",   "b",   16'h0005);  // later write replaces
    drive_item(KIND_LOOKUP,   "a",   "b",   16'h0000);
    drive_item(KIND_WILDCARD, "X",   8'hFF, 16'h0064);  // folded on add
    drive_item(KIND_LOOKUP,   "x",   "q",   16'h0000);
    drive_item(KIND_LOOKUP,   "q",   "X",   16'h0000);
    drive_item(KIND_WILDCARD, "x",   8'h00, 16'h00C8);  // second slot, same char
    drive_item(KIND_LOOKUP,   "x",   "x",   16'h0000);  // first slot wins
    drive_item(KIND_WILDCARD, "a",   8'h00, 16'h0007);
    drive_item(KIND_LOOKUP,   "a",   "b",   16'h0000);  // table beats wildcard
    drive_item(KIND_LOOKUP,   "a",   "z",   16'h0000);
    drive_item(KIND_LOOKUP,   8'h40, 8'h60, 16'h0000);  // just below A and a
    drive_item(KIND_LOOKUP,   "Z",   "z",   16'h0000);
    drive_item(KindUnused,    8'hFF, 8'hFF, 16'h8000);
    drive_item(KIND_LOOKUP,   8'h00, 8'h00, 16'hFFFF);
    start <= 1'b0;
    drain();

    // Settings sweep: extremes first, then random
    write_regs(16'h7FFF, 16'h8000, 1'b0, 1'b1);
    run_phase(240);
    drain();
    write_regs(16'h8000, 16'h7FFF, 1'b1, 1'b1);
    run_phase(240);
    drain();
    write_regs(16'h0000, 16'h0000, 1'b0, 1'b0);
    run_phase(240);
    drain();
    write_regs(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    run_phase(240);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_phase(240);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      board.report($sformatf("%0d expected beats never arrived", board.outstanding()));
    end
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
